// ===== rtl/core/swm_pkg.sv =====
// Shared constants and types for the sliding window median filter.
package swm_pkg;
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 7;
  localparam int OUT_W       = SAMPLE_BITS + 1;
  localparam logic [CFG_W-1:0] WIN_RESET = 7'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  // Memory port request from the sequencer to the sorted store.
  typedef struct packed {
    logic    rd_en;
    idx_t    rd_addr;
    logic    wr_en;
    idx_t    wr_addr;
    sample_t wr_data;
  } mem_req_t;
endpackage

// ===== rtl/core/swm_ram.sv =====
// Single-port-write, one-read synchronous RAM with registered read data.
module swm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/core/sliding_window_median.sv =====
// Sliding window median: top level with sequencer over sorted store and arrival ring.
// Per sample with the window full: read the oldest value from the ring, scan the sorted store
// for it, shift the entries above it down, insert the new sample, then read the median.
// Throughput: one sample in flight; the next beat is taken once the sequencer is idle,
// and a waiting result holds in its own output register, so input goes on until the next result must wait in S_OUT.
// Reset (rst_n low, synchronous): window size 3, window emptied, no result pending.
module sliding_window_median (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,     // window_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [15:0] sample
  input  logic        in_tuser,      // [0] first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // [16:0] median_times_two, zero fill above
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ORD    = 4'd1; // not entered; S_IDLE itself issues the read of the oldest from the ring
  localparam logic [3:0] S_ORDW   = 4'd2;
  localparam logic [3:0] S_RFIND  = 4'd3; // scan sorted for oldest value
  localparam logic [3:0] S_RSHIFT = 4'd4; // shift entries down over removed slot
  localparam logic [3:0] S_INS    = 4'd5; // shift entries up from top until place found
  localparam logic [3:0] S_MED0   = 4'd6;
  localparam logic [3:0] S_MED1   = 4'd7;
  localparam logic [3:0] S_MED2   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]             state_r, state_nxt;
  logic [6:0]             win_r;
  swm_pkg::cnt_t          fill_r, fill_nxt;
  swm_pkg::idx_t          old_r, old_nxt;
  swm_pkg::sample_t       smp_r, smp_nxt;
  swm_pkg::sample_t       oldv_r, oldv_nxt;
  swm_pkg::cnt_t          i_r, i_nxt;
  swm_pkg::cnt_t          n_r, n_nxt;
  logic                   rdv_r, rdv_nxt;
  logic signed [swm_pkg::OUT_W-1:0] acc_r, acc_nxt;
  logic signed [swm_pkg::OUT_W-1:0] res_r, res_nxt;
  logic                   emit_r, emit_nxt;
  swm_pkg::cnt_t          w_eff;
  swm_pkg::mem_req_t      sreq, rreq;
  swm_pkg::sample_t       s_rd, r_rd;

  // Effective window: clamp to 1..MAX_WINDOW.
  always_comb begin
    if (win_r == '0) begin
      w_eff = swm_pkg::cnt_t'(1);
    end else if (win_r > 7'(swm_pkg::MAX_WINDOW)) begin
      w_eff = swm_pkg::cnt_t'(swm_pkg::MAX_WINDOW);
    end else begin
      w_eff = swm_pkg::cnt_t'(win_r);
    end
  end

  swm_ram #(.DEPTH(swm_pkg::MAX_WINDOW), .WIDTH(swm_pkg::SAMPLE_BITS)) u_sorted (
    .clk(clk), .wr_en(sreq.wr_en), .wr_addr(sreq.wr_addr), .wr_data(sreq.wr_data),
    .rd_en(sreq.rd_en), .rd_addr(sreq.rd_addr), .rd_data(s_rd));

  swm_ram #(.DEPTH(swm_pkg::MAX_WINDOW), .WIDTH(swm_pkg::SAMPLE_BITS)) u_ring (
    .clk(clk), .wr_en(rreq.wr_en), .wr_addr(rreq.wr_addr), .wr_data(rreq.wr_data),
    .rd_en(rreq.rd_en), .rd_addr(rreq.rd_addr), .rd_data(r_rd));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = emit_r;
  assign out_tdata  = {7'd0, res_r};

  // Sequencer. Reads issued in one cycle return data the next (rdv_r marks it).
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    old_nxt   = old_r;
    smp_nxt   = smp_r;
    oldv_nxt  = oldv_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    rdv_nxt   = 1'b0;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    emit_nxt  = emit_r;
    sreq      = '0;
    rreq      = '0;
    if (emit_r && out_tready) begin
      emit_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          smp_nxt = swm_pkg::sample_t'(in_tdata);
          if (in_tuser || fill_r < w_eff) begin
            // Still filling: append to ring, insert among n held entries.
            if (in_tuser) begin
              fill_nxt = swm_pkg::cnt_t'(1);
              old_nxt  = '0;
              n_nxt    = '0;
            end else begin
              fill_nxt = fill_r + 1'b1;
              n_nxt    = fill_r;
            end
            rreq.wr_en   = 1'b1;
            rreq.wr_addr = in_tuser ? '0 : swm_pkg::idx_t'(fill_r);
            rreq.wr_data = swm_pkg::sample_t'(in_tdata);
            i_nxt        = in_tuser ? '0 : fill_r;
            state_nxt    = S_INS;
          end else begin
            rreq.rd_en   = 1'b1;
            rreq.rd_addr = old_r;
            state_nxt    = S_ORDW;
          end
        end
      end
      S_ORD: begin
        state_nxt = S_ORDW;
      end
      S_ORDW: begin
        // Oldest value arrives; overwrite ring slot and advance pointer.
        oldv_nxt     = r_rd;
        rreq.wr_en   = 1'b1;
        rreq.wr_addr = old_r;
        rreq.wr_data = smp_r;
        old_nxt      = (swm_pkg::cnt_t'(old_r) + 1'b1 >= w_eff) ? '0 : old_r + 1'b1;
        i_nxt        = '0;
        sreq.rd_en   = 1'b1;
        sreq.rd_addr = '0;
        rdv_nxt      = 1'b1;
        state_nxt    = S_RFIND;
      end
      S_RFIND: begin
        if (rdv_r) begin
          if (s_rd == oldv_r || i_r + 1'b1 >= w_eff) begin
            state_nxt = S_RSHIFT;
            if (i_r + 1'b1 < w_eff) begin
              sreq.rd_en   = 1'b1;
              sreq.rd_addr = swm_pkg::idx_t'(i_r + 1'b1);
              rdv_nxt      = 1'b1;
            end
          end else begin
            i_nxt        = i_r + 1'b1;
            sreq.rd_en   = 1'b1;
            sreq.rd_addr = swm_pkg::idx_t'(i_r + 1'b1);
            rdv_nxt      = 1'b1;
          end
        end
      end
      S_RSHIFT: begin
        // Move entry i+1 to i until top reached; then insert among W-1.
        if (rdv_r) begin
          sreq.wr_en   = 1'b1;
          sreq.wr_addr = swm_pkg::idx_t'(i_r);
          sreq.wr_data = s_rd;
          i_nxt        = i_r + 1'b1;
          if (i_r + 2'd2 < w_eff) begin
            sreq.rd_en   = 1'b1;
            sreq.rd_addr = swm_pkg::idx_t'(i_r + 2'd2);
            rdv_nxt      = 1'b1;
          end
        end else begin
          n_nxt     = w_eff - 1'b1;
          i_nxt     = w_eff - 1'b1;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        // i is the free slot; compare with entry i-1 and shift it up if larger.
        if (i_r == '0) begin
          sreq.wr_en   = 1'b1;
          sreq.wr_addr = '0;
          sreq.wr_data = smp_r;
          state_nxt    = S_MED0;
        end else if (!rdv_r) begin
          sreq.rd_en   = 1'b1;
          sreq.rd_addr = swm_pkg::idx_t'(i_r - 1'b1);
          rdv_nxt      = 1'b1;
        end else if (s_rd > smp_r) begin
          sreq.wr_en   = 1'b1;
          sreq.wr_addr = swm_pkg::idx_t'(i_r);
          sreq.wr_data = s_rd;
          i_nxt        = i_r - 1'b1;
        end else begin
          sreq.wr_en   = 1'b1;
          sreq.wr_addr = swm_pkg::idx_t'(i_r);
          sreq.wr_data = smp_r;
          state_nxt    = S_MED0;
        end
      end
      S_MED0: begin
        if (fill_r < w_eff) begin
          state_nxt = S_IDLE;
        end else begin
          sreq.rd_en   = 1'b1;
          sreq.rd_addr = swm_pkg::idx_t'(w_eff >> 1);
          state_nxt    = S_MED1;
        end
      end
      S_MED1: begin
        acc_nxt = swm_pkg::OUT_W'(s_rd);
        if (w_eff[0]) begin
          acc_nxt   = {s_rd, 1'b0};
          state_nxt = S_OUT;
        end else begin
          sreq.rd_en   = 1'b1;
          sreq.rd_addr = swm_pkg::idx_t'((w_eff >> 1) - 1'b1);
          state_nxt    = S_MED2;
        end
      end
      S_MED2: begin
        acc_nxt   = acc_r + swm_pkg::OUT_W'(s_rd);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hand over to the output register once it is free or being drained.
        if (!emit_r || out_tready) begin
          res_nxt   = acc_r;
          emit_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r   <= swm_pkg::WIN_RESET;
      fill_r  <= '0;
      old_r   <= '0;
      rdv_r   <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      emit_r  <= emit_nxt;
      if (cfg_we) begin
        win_r  <= cfg_wdata;
        fill_r <= '0;
        old_r  <= '0;
      end else begin
        fill_r <= fill_nxt;
        old_r  <= old_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    smp_r  <= smp_nxt;
    oldv_r <= oldv_nxt;
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  // Checks.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= swm_pkg::cnt_t'(swm_pkg::MAX_WINDOW))
    else $error("fill count beyond window");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped while stalled");
  a_ins_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (i_r <= n_r))
    else $error("insert slot above held count");
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 100ps

module testbench;
  localparam int LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  sliding_window_median DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: sorted window, arrival ring, fill and oldest slot
  swm_pkg::sample_t         win_sorted[swm_pkg::MAX_WINDOW];
  swm_pkg::sample_t         win_ring[swm_pkg::MAX_WINDOW];
  int                       win_fill;
  int                       win_oldest;
  logic [swm_pkg::CFG_W-1:0] win_size;

  logic signed [swm_pkg::OUT_W-1:0] medians_due[$];

  int  errors;
  int  cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;

  // Directed stimulus table; want_chk/want is filled only where obvious
  typedef struct {
    logic [swm_pkg::CFG_W-1:0]        cfg;
    bit                               do_cfg;
    swm_pkg::sample_t                 smp;
    bit                               first;
    bit                               want_chk;
    logic signed [swm_pkg::OUT_W-1:0] want;
  } dir_row_t;

  function automatic int eff_window();
    int w;
    w = int'(win_size);
    if (w < 1) w = 1;
    if (w > swm_pkg::MAX_WINDOW) w = swm_pkg::MAX_WINDOW;
    return w;
  endfunction

  task automatic set_window(input logic [swm_pkg::CFG_W-1:0] v);
    win_size   = v;
    win_fill   = 0;
    win_oldest = 0;
  endtask

  // Advance the running median by one sample; queues the doubled median if full
  task automatic median_step(input swm_pkg::sample_t s, input bit first);
    int w, i;
    swm_pkg::sample_t gone;
    logic signed [swm_pkg::OUT_W-1:0] due;
    w = eff_window();
    if (first) begin
      win_fill   = 0;
      win_oldest = 0;
    end
    if (win_fill > w) win_fill = w;
    if (win_oldest >= w) win_oldest = 0;
    if (win_fill < w) begin
      i = win_fill;
      while (i > 0 && win_sorted[i-1] > s) begin
        win_sorted[i] = win_sorted[i-1];
        i--;
      end
      win_sorted[i]      = s;
      win_ring[win_fill] = s;
      win_fill++;
    end else begin
      // drop one copy of the oldest value, then insert the new one
      gone = win_ring[win_oldest];
      i = 0;
      while (i < w && win_sorted[i] != gone) i++;
      if (i >= w) i = w - 1;
      for (int j = i; j < w - 1; j++) win_sorted[j] = win_sorted[j+1];
      i = w - 1;
      while (i > 0 && win_sorted[i-1] > s) begin
        win_sorted[i] = win_sorted[i-1];
        i--;
      end
      win_sorted[i]        = s;
      win_ring[win_oldest] = s;
      win_oldest++;
      if (win_oldest >= w) win_oldest = 0;
    end
    if (win_fill >= w) begin
      if (w % 2)
        due = swm_pkg::OUT_W'(2 * int'(win_sorted[w/2]));
      else
        due = swm_pkg::OUT_W'(int'(win_sorted[w/2-1]) + int'(win_sorted[w/2]));
      medians_due = {medians_due, due};
    end
  endtask

  // Send one beat, updating the prediction on acceptance; valid stays up after
  task automatic send_sample(input swm_pkg::sample_t s, input bit first);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    median_step(s, first);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (medians_due.size() != 0) @(negedge clk);
    // last item may have been absorbed with no result; wait out the latency
    repeat (2 * swm_pkg::MAX_WINDOW + 10) @(negedge clk);
  endtask

  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_window(v);
  endtask

  // Mostly valid windows with random content; a few sequence restarts
  task automatic random_run(input int n);
    int k;
    swm_pkg::sample_t s;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: s = swm_pkg::sample_t'($urandom);
        1: s = swm_pkg::sample_t'(int'($urandom_range(8)) - 4);
        2: s = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        default: s = swm_pkg::sample_t'(int'($urandom_range(200)) - 100);
      endcase
      send_sample(s, $urandom_range(49) == 0);
    end
  endtask

  // Receiver
  always @(negedge clk) begin
    if (hold_off)
      out_tready <= 1'b0;
    else
      out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (medians_due.size() == 0) begin
        $error("median_times_two: unexpected result %0d", $signed(out_tdata[16:0]));
        errors++;
      end else begin
        if (out_tdata[16:0] !== medians_due[0]) begin
          $error("median_times_two: expected %0d, actual %0d",
                 medians_due[0], $signed(out_tdata[16:0]));
          errors++;
        end
        if (out_tdata[23:17] !== 7'd0) begin
          $error("out_tdata fill: expected 0, actual %0h", out_tdata[23:17]);
          errors++;
        end
        void'(medians_due.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0; rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; out_tready = 1'b0;
    errors = 0; cycles = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0;
    set_window(swm_pkg::WIN_RESET);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset window of 3, extremes, window 1, zero, above max, even, ties
    dir_rows = '{
      '{0, 0, 16'sh7fff, 0, 0, 0},
      '{0, 0, 16'sh7fff, 0, 0, 0},
      '{0, 0, 16'sh7fff, 0, 1, 17'sd65534},
      '{0, 0, 16'sh8000, 0, 0, 0},
      '{0, 0, 16'sh8000, 0, 1, -17'sd65536},
      '{0, 0, 16'sh0005, 1, 0, 0},
      '{1, 1, 16'sh1234, 0, 1, 17'sh02468},
      '{1, 1, 16'shedcb, 0, 0, 0},
      '{0, 1, 16'sh7fff, 0, 1, 17'sd65534},
      '{0, 1, 16'sh8000, 1, 1, -17'sd65536},
      '{127, 1, 16'sh0001, 0, 0, 0},
      '{2, 1, 16'sh7fff, 0, 0, 0},
      '{2, 0, 16'sh8000, 0, 1, -17'sd1},
      '{2, 0, 16'sh0003, 0, 0, 0},
      '{4, 1, 16'sh0002, 0, 0, 0},
      '{4, 0, 16'sh0002, 0, 0, 0},
      '{4, 0, 16'sh0002, 0, 0, 0},
      '{4, 0, 16'sh0007, 0, 1, 17'sd4},
      '{4, 0, 16'sh0002, 0, 0, 0},
      '{4, 0, 16'shffff, 0, 0, 0}
    };
    foreach (dir_rows[r]) begin
      if (dir_rows[r].do_cfg) write_window(dir_rows[r].cfg);
      send_sample(dir_rows[r].smp, dir_rows[r].first);
      if (dir_rows[r].want_chk && medians_due.size() != 0 &&
          medians_due[$] !== dir_rows[r].want) begin
        $error("median_times_two: table expected %0d, predicted %0d",
               dir_rows[r].want, medians_due[$]);
        errors++;
      end
    end
    // window 0 acts as 1; window 64 fills the whole store
    write_window(7'd0);
    send_sample(16'sh0042, 1'b0);
    write_window(7'd64);
    random_run(130);

    // Random phases over idle patterns and window sizes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 35) : 0;
      recv_stall_pct = (ph == 2) ? 67 : ((ph == 3) ? 35 : 0);
      for (int sub = 0; sub < 4; sub++) begin
        write_window(7'($urandom_range(1, (sub == 3) ? 64 : 9)));
        random_run(55);
      end
    end

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0; recv_stall_pct = 0;
    write_window(7'd3);
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      random_run(40);
    join
    drain();
    random_run(30);

    drain();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
